@@ hw/rtl/c3rb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c3rb_pkg;

    typedef logic [7:0] pixel_t;

    // window indexed [row][col], row 0 oldest line, col 0 oldest column
    typedef logic [2:0][2:0][7:0] win_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int POS_W = 11;
    localparam int SUM_W = 13;
    localparam int SCALE_W = 17;
    localparam int PROD_W = 29;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 2'd2;

    localparam logic [1:0] MODE_SHARPEN = 2'd0;
    localparam logic [1:0] MODE_AVERAGE = 2'd1;
    localparam logic [1:0] MODE_EMBOSS = 2'd2;

    // unsigned q1.16 scales
    localparam logic [SCALE_W-1:0] SCALE_SHARPEN = 17'd65536;
    localparam logic [SCALE_W-1:0] SCALE_AVERAGE = 17'd7281;
    localparam logic [SCALE_W-1:0] SCALE_EMBOSS = 17'd21627;

    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 12'd480;

endpackage

`default_nettype wire

@@ hw/rtl/conv3x3_replicate_border_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 3x3 convolution over a raster-order grey frame with replicated borders. One pixel is
// taken per clock while the job queue has room; results leave at up to one per clock.
// Each pixel beat reads its column of the single dual-line store (older and newer line
// side by side) when it is taken and writes it back in the next cycle, so the memory
// port does one read and one write per clock. Result pixel (r-1, c-1) is produced by
// input (r, c); inputs of the last row also produce that row's results, up to four
// results per beat, and there the input rate falls to the output rate through a
// four-deep job queue. Input to first result: store read, window update, kernel sum,
// scale multiply, clamp into the output register. The line store needs no clearing
// pass: entries are always written in a frame before their data are used.
module conv3x3_replicate_border_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [c3rb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [c3rb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire c3rb_pkg::pixel_t                    in_pixel,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output c3rb_pkg::pixel_t                         out_pixel,
    output logic [c3rb_pkg::POS_W-1:0]               out_col,
    output logic [c3rb_pkg::POS_W-1:0]               out_row,
    output logic                                     run_last,
    output logic                                     frame_last
);
    import c3rb_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PW = $clog2(FIFO_DEPTH);

    typedef struct packed {
        win_t          win;
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic          r_ge1;
        logic          r_ge2;
        logic          c_ge1;
        logic          c_ge2;
        logic [3:0]    mask;
    } job_t;

    // configuration
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [1:0]            kernel_mode_reg;

    // position counters
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] wlast;
    logic [RW-1:0] hlast;
    logic [31:0]   fw_ext, fh_ext;
    logic          endcol, endrow;
    logic          accept;

    // line store
    logic [15:0] line_mem [MAX_WIDTH];
    logic [15:0] mem_rd_reg;
    logic        fwd_hit_reg;
    logic [15:0] fwd_data_reg;

    // window stage
    logic          s1_valid_reg;
    pixel_t        s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_endcol_reg, s1_endrow_reg;
    pixel_t        s1_top, s1_mid;
    win_t          win_reg, win_next;
    job_t          s1_job;
    logic          push;

    // job queue
    job_t          fifo_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          pop, issue;
    job_t          head;
    logic [3:0]    issued_reg, rem, sel;
    logic          sel_last;

    // sum stage
    logic               pass1, endsel;
    logic [1:0]         rs [3];
    logic [1:0]         cs [3];
    pixel_t             nb [3][3];
    logic signed [SUM_W-1:0] total, sum;
    logic [31:0]        ycol_ext, yrow_ext;
    logic               a_valid_reg;
    logic signed [SUM_W-1:0] a_sum_reg;
    logic [1:0]         a_mode_reg;
    logic [POS_W-1:0]   a_col_reg, a_row_reg;
    logic               a_run_last_reg, a_frame_last_reg;

    // multiply stage
    logic [SCALE_W-1:0] scale;
    logic               b_valid_reg;
    logic [PROD_W-1:0]  b_prod_reg;
    logic [POS_W-1:0]   b_col_reg, b_row_reg;
    logic               b_run_last_reg, b_frame_last_reg;

    // output register
    logic               out_valid_reg;
    pixel_t             out_pixel_reg;
    logic [POS_W-1:0]   out_col_reg, out_row_reg;
    logic               run_last_reg, frame_last_reg;
    logic [SUM_W-1:0]   scaled;

    logic out_en, b_en, a_en;

    always_comb
    begin
        fw_ext = 32'(frame_width_reg);
        fh_ext = 32'(frame_height_reg);
        if (fw_ext == 32'd0)
        begin
            wlast = '0;
        end
        else if (fw_ext > 32'(MAX_WIDTH))
        begin
            wlast = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = CW'(fw_ext - 32'd1);
        end
        if (fh_ext == 32'd0)
        begin
            hlast = '0;
        end
        else if (fh_ext > 32'(MAX_HEIGHT))
        begin
            hlast = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hlast = RW'(fh_ext - 32'd1);
        end
    end

    assign endcol = (col_count_reg == wlast);
    assign endrow = (row_count_reg == hlast);
    assign in_ready = ({1'b0, count_reg} + {{(PW+1){1'b0}}, s1_valid_reg})
        <= (PW+2)'(FIFO_DEPTH - 1);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (accept)
        begin
            if (endcol)
            begin
                col_count_next = '0;
                row_count_next = endrow ? '0 : row_count_reg + RW'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            kernel_mode_reg <= MODE_SHARPEN;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg <= cfg_wdata;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    REG_KERNEL_MODE:  kernel_mode_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // line store: read on the taken beat, write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_rd_reg <= line_mem[col_count_reg];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {s1_mid, s1_px_reg};
        end
    end

    assign s1_top = fwd_hit_reg ? fwd_data_reg[15:8] : mem_rd_reg[15:8];
    assign s1_mid = fwd_hit_reg ? fwd_data_reg[7:0] : mem_rd_reg[7:0];

    always_comb
    begin
        win_next = win_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = s1_top;
        win_next[1][2] = s1_mid;
        win_next[2][2] = s1_px_reg;

        s1_job.win = win_next;
        s1_job.col = s1_col_reg;
        s1_job.row = s1_row_reg;
        s1_job.r_ge1 = (s1_row_reg != '0);
        s1_job.r_ge2 = (32'(s1_row_reg) >= 32'd2);
        s1_job.c_ge1 = (s1_col_reg != '0);
        s1_job.c_ge2 = (32'(s1_col_reg) >= 32'd2);
        s1_job.mask[0] = s1_job.r_ge1 && s1_job.c_ge1;
        s1_job.mask[1] = s1_job.r_ge1 && s1_endcol_reg;
        s1_job.mask[2] = s1_endrow_reg && s1_job.c_ge1;
        s1_job.mask[3] = s1_endrow_reg && s1_endcol_reg;
    end

    assign push = s1_valid_reg && (s1_job.mask != 4'b0000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            win_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                fwd_hit_reg <= s1_valid_reg && (s1_col_reg == col_count_reg);
            end
            if (s1_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg <= in_pixel;
            s1_col_reg <= col_count_reg;
            s1_row_reg <= row_count_reg;
            s1_endcol_reg <= endcol;
            s1_endrow_reg <= endrow;
            fwd_data_reg <= {s1_mid, s1_px_reg};
        end
    end

    // job queue and result sequencing
    assign out_en = !out_valid_reg || out_ready;
    assign b_en = !b_valid_reg || out_en;
    assign a_en = !a_valid_reg || b_en;

    assign head = fifo_reg[rd_ptr_reg];
    assign rem = head.mask & ~issued_reg;
    assign sel = rem & (~rem + 4'd1);
    assign sel_last = ((rem & ~sel) == 4'b0000);
    assign issue = (count_reg != '0) && a_en;
    assign pop = issue && sel_last;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= s1_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            issued_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
            if (issue)
            begin
                issued_reg <= sel_last ? 4'b0000 : (issued_reg | sel);
            end
        end
    end

    // kernel sum over the selected neighborhood
    always_comb
    begin
        pass1 = sel[2] || sel[3];
        endsel = sel[1] || sel[3];
        rs[0] = pass1 ? (head.r_ge1 ? 2'd1 : 2'd2) : (head.r_ge2 ? 2'd0 : 2'd1);
        rs[1] = pass1 ? 2'd2 : 2'd1;
        rs[2] = 2'd2;
        cs[0] = endsel ? (head.c_ge1 ? 2'd1 : 2'd2) : (head.c_ge2 ? 2'd0 : 2'd1);
        cs[1] = endsel ? 2'd2 : 2'd1;
        cs[2] = 2'd2;
        total = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                nb[i][j] = head.win[rs[i]][cs[j]];
                total = total + $signed({5'b0, nb[i][j]});
            end
        end
        case (kernel_mode_reg)
            MODE_AVERAGE:
            begin
                sum = total;
            end
            MODE_EMBOSS:
            begin
                sum = $signed({5'b0, nb[0][1]}) + $signed({5'b0, nb[1][1]})
                    + $signed({5'b0, nb[1][2]}) + $signed({5'b0, nb[2][1]})
                    + $signed({4'b0, nb[2][2], 1'b0}) - $signed({4'b0, nb[0][0], 1'b0})
                    - $signed({5'b0, nb[1][0]});
            end
            default:
            begin
                sum = $signed({2'b0, nb[1][1], 3'b0}) + $signed({4'b0, nb[1][1], 1'b0})
                    - total;
            end
        endcase
        ycol_ext = endsel ? 32'(head.col) : 32'(head.col) - 32'd1;
        yrow_ext = pass1 ? 32'(head.row) : 32'(head.row) - 32'd1;
    end

    always_comb
    begin
        case (a_mode_reg)
            MODE_AVERAGE: scale = SCALE_AVERAGE;
            MODE_EMBOSS:  scale = SCALE_EMBOSS;
            default:      scale = SCALE_SHARPEN;
        endcase
    end

    assign scaled = b_prod_reg[PROD_W-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= issue;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_sum_reg <= sum;
            a_mode_reg <= kernel_mode_reg;
            a_col_reg <= ycol_ext[POS_W-1:0];
            a_row_reg <= yrow_ext[POS_W-1:0];
            a_run_last_reg <= sel_last;
            a_frame_last_reg <= sel[3];
        end
        if (b_en && a_valid_reg)
        begin
            b_prod_reg <= (a_sum_reg > 0)
                ? PROD_W'(a_sum_reg[SUM_W-2:0]) * PROD_W'(scale) : '0;
            b_col_reg <= a_col_reg;
            b_row_reg <= a_row_reg;
            b_run_last_reg <= a_run_last_reg;
            b_frame_last_reg <= a_frame_last_reg;
        end
        if (out_en && b_valid_reg)
        begin
            out_pixel_reg <= (scaled > SUM_W'(255)) ? 8'd255 : scaled[7:0];
            out_col_reg <= b_col_reg;
            out_row_reg <= b_row_reg;
            run_last_reg <= b_run_last_reg;
            frame_last_reg <= b_frame_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_col = out_col_reg;
    assign out_row = out_row_reg;
    assign run_last = run_last_reg;
    assign frame_last = frame_last_reg;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(FIFO_DEPTH))
        else $error("job queue over capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < (PW+1)'(FIFO_DEPTH) || pop))
        else $error("job pushed into a full queue");

    a_forward_src: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_hit_reg) |-> $past(s1_valid_reg))
        else $error("line store forward without a pending write");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_last_reg) |-> run_last_reg)
        else $error("frame end beat not last of its run");

endmodule

`default_nettype wire
